### rtl/core/assert_macros.svh
// assertion macros shared by the mixer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define SSVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// a condition that must be followed by another in the next cycle
`define SSVM_ASSERT_NEXT(lbl, cond, nxt, msg) \
  `SSVM_ASSERT(lbl, (cond) |=> (nxt), msg)

`endif

### rtl/core/ssvm_pkg.sv
// shared types, codes and the sine table function of the voice mixer
package ssvm_pkg;

  localparam logic FUNC_SCHED = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam longint unsigned PiHalfQ30 = 64'd1686629713;
  localparam longint unsigned Q30One    = 64'd1 << 30;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new transaction
    logic sweep;  // visit voice idx this cycle
    logic fin;    // publish the result
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_FLUSH1 = 5'b00100,
    ST_FLUSH2 = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  // sin(pi/2 * j / 2^qb) scaled by 32767, q30 taylor series
  function automatic logic [14:0] quarter_sine(longint unsigned j, int qb);
    longint unsigned theta;
    longint unsigned t;
    longint unsigned r;
    longint unsigned s;
    longint unsigned v;
    theta = (j * PiHalfQ30) >> qb;
    t = (theta * theta) >> 30;
    r = Q30One;
    r = Q30One - ((t * r) >> 30) / 110;
    r = Q30One - ((t * r) >> 30) / 72;
    r = Q30One - ((t * r) >> 30) / 42;
    r = Q30One - ((t * r) >> 30) / 20;
    r = Q30One - ((t * r) >> 30) / 6;
    s = (theta * r) >> 30;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

### rtl/core/ssvm_ram.sv
// generic single write port, single read port ram with registered read
module ssvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/ssvm_ctrl.sv
// sequencer that sweeps the voices once per transaction
module ssvm_ctrl #(
  parameter int VOICES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output ssvm_pkg::cmd_t       cmd_o,
  output logic [$clog2(VOICES > 1 ? VOICES : 2)-1:0] idx_o
);
  import ssvm_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(VOICES > 1 ? VOICES : 2);
  localparam logic [AW-1:0] LastIdx = AW'(VOICES - 1);

  state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;

  assign busy = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.sweep = 1'b1;
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == LastIdx) begin
          state_d = ST_FLUSH1;
        end
      end
      ST_FLUSH1: state_d = ST_FLUSH2;
      ST_FLUSH2: state_d = ST_FIN;
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign idx_o = cnt_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `SSVM_ASSERT_NEXT(a_accept_busy, start && !busy, busy && state_q == ST_RUN && cnt_q == '0,
                    "accepted transaction did not start the sweep at voice zero")

endmodule

### rtl/core/ssvm_dp.sv
// voice datapath: voice store, sine lookup, multiply and mix
module ssvm_dp #(
  parameter int VOICES          = 16,
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssvm_pkg::cmd_t       cmd_i,
  input  logic [$clog2(VOICES > 1 ? VOICES : 2)-1:0] idx_i,
  input  logic                 func_i,
  input  logic [31:0]          start_delay_i,
  input  logic [23:0]          phase_step_i,
  input  logic [14:0]          amplitude_i,
  input  logic [31:0]          duration_i,
  output logic                 done_o,
  output logic signed [15:0]   sample_out_o,
  output logic                 sample_valid_o,
  output logic                 rejected_o
);
  import ssvm_pkg::*;
  `include "assert_macros.svh"

  localparam int AW    = $clog2(VOICES > 1 ? VOICES : 2);
  localparam int PB    = PHASE_BITS;
  localparam int TB    = SINE_TABLE_BITS;
  localparam int QB    = TB - 2;
  localparam int QN    = (1 << QB) + 1;
  localparam int EW    = 64 + 2 * PB + 15;
  localparam int ACC_W = 33 + AW;
  localparam logic [QB:0] QFull = (QB + 1)'(1 << QB);

  // captured transaction
  logic          func_q;
  logic [31:0]   delay_q;
  logic [PB-1:0] step_q;
  logic [14:0]   gain_q;
  logic [31:0]   dur_q;
  logic [31:0]   step_ext;

  assign step_ext = {8'd0, phase_step_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      delay_q <= start_delay_i;
      step_q  <= step_ext[PB-1:0];
      gain_q  <= amplitude_i;
      dur_q   <= duration_i;
    end
  end

  // voice store
  logic          we;
  logic [AW-1:0] s1_idx_q;
  logic [EW-1:0] wdata, rdata;

  ssvm_ram #(.WIDTH(EW), .DEPTH(VOICES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_idx_q),
    .wdata_i (wdata),
    .raddr_i (idx_i),
    .rdata_o (rdata)
  );

  // stage one tracks the voice whose entry is on the read port
  logic s1_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      s1_idx_q <= idx_i;
    end
  end

  // unpack the stored voice
  logic [31:0]   rd_delay, rd_rem;
  logic [PB-1:0] rd_phase, rd_step;
  logic [14:0]   rd_gain;
  assign {rd_delay, rd_rem, rd_phase, rd_step, rd_gain} = rdata;

  // quarter wave table
  logic [14:0] qtab [QN];
  for (genvar g = 0; g < QN; g++) begin : g_qtab
    assign qtab[g] = quarter_sine(64'(g), QB);
  end

  // sine lookup from the phase
  logic [PB+TB-1:0]   phase_ext;
  logic [TB-1:0]      tidx;
  logic [1:0]         quad;
  logic [QB:0]        jj;
  logic signed [15:0] mag, sine;
  assign phase_ext = {rd_phase, TB'(0)};
  assign tidx      = phase_ext[PB+TB-1 -: TB];
  assign quad      = tidx[TB-1 -: 2];
  assign jj        = quad[0] ? (QFull - {1'b0, tidx[QB-1:0]}) : {1'b0, tidx[QB-1:0]};
  assign mag       = $signed({1'b0, qtab[jj]});
  assign sine      = quad[1] ? -mag : mag;

  // per voice update
  logic [VOICES-1:0] active_q, active_d;
  logic              found_q, found_d;
  logic              cur_act, sounding;
  assign cur_act  = active_q[s1_idx_q];
  assign sounding = s1_v_q && func_q == FUNC_TICK && cur_act && rd_delay == '0;

  always_comb begin
    active_d = active_q;
    found_d  = found_q;
    we       = 1'b0;
    wdata    = rdata;
    if (s1_v_q) begin
      if (func_q == FUNC_SCHED) begin
        if (!found_q && !cur_act && dur_q != '0) begin
          we                 = 1'b1;
          wdata              = {delay_q, dur_q, PB'(0), step_q, gain_q};
          active_d[s1_idx_q] = 1'b1;
          found_d            = 1'b1;
        end
      end else if (cur_act) begin
        we = 1'b1;
        if (rd_delay != '0) begin
          wdata = {rd_delay - 32'd1, rd_rem, rd_phase, rd_step, rd_gain};
        end else begin
          wdata = {rd_delay, rd_rem - 32'd1, rd_phase + rd_step, rd_step, rd_gain};
          if (rd_rem == 32'd1) begin
            active_d[s1_idx_q] = 1'b0;
          end
        end
      end
    end
    if (cmd_i.load) begin
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      found_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      found_q  <= found_d;
    end
  end

  // product register
  logic               prod_v_q;
  logic signed [31:0] prod_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= sounding;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sounding) begin
      prod_q <= $signed({17'd0, rd_gain}) * 32'(sine);
    end
  end

  // accumulator
  logic signed [ACC_W-1:0] acc_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round to q15 and saturate
  logic signed [ACC_W-1:0] rnd, shr;
  logic signed [15:0]      sat;
  assign rnd = acc_q + ACC_W'(16384);
  assign shr = rnd >>> 15;
  always_comb begin
    if (shr > ACC_W'(32767)) begin
      sat = 16'sd32767;
    end else if (shr < -ACC_W'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = shr[15:0];
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      sample_out_o   <= (func_q == FUNC_TICK) ? sat : 16'sd0;
      sample_valid_o <= (func_q == FUNC_TICK);
      rejected_o     <= (func_q == FUNC_SCHED) && dur_q != '0 && !found_q;
    end
  end

  `SSVM_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe lasted more than one cycle")
  `SSVM_ASSERT(a_rej_excl, done_o |-> !(rejected_o && sample_valid_o),
               "tick result flagged as rejected")

endmodule

### rtl/core/scheduled_sine_voice_mixer.sv
// top level of the polyphonic sine voice mixer
//
// One command channel: an item is taken when start is high and busy is low.
// func 0 places a note (delay, phase step, amplitude, duration) in the
// lowest-numbered free voice; func 1 makes one mixed output sample.
// Each transaction yields exactly one result, shown for one cycle with
// done_o high: sample_out_o/sample_valid_o for ticks, rejected_o for notes.
// Sequence after accept: the RUN sweep, FLUSH1, FLUSH2 and FIN, with done_o
// registered from FIN; busy stays high from RUN through FIN. Both ops sweep every
// voice through the single read port of the voice store, one voice per cycle.
// A new item may be accepted in the cycle done_o is high.
// Reset clears all voice active bits and the sequencer; voice contents are
// only used while a voice is active, so the store needs no clearing pass.
// The receiver cannot stall: done_o is a strobe and must be taken.
module scheduled_sine_voice_mixer #(
  parameter int VOICES          = 16,
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [31:0]        start_delay_i,
  input  logic [23:0]        phase_step_i,
  input  logic [14:0]        amplitude_i,
  input  logic [31:0]        duration_i,
  output logic               done_o,
  output logic signed [15:0] sample_out_o,
  output logic               sample_valid_o,
  output logic               rejected_o
);
  import ssvm_pkg::*;

  localparam int AW = $clog2(VOICES > 1 ? VOICES : 2);

  cmd_t          cmd;
  logic [AW-1:0] idx;

  // sequencer
  ssvm_ctrl #(.VOICES(VOICES)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .idx_o  (idx)
  );

  // datapath
  ssvm_dp #(
    .VOICES          (VOICES),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .func_i         (func_i),
    .start_delay_i  (start_delay_i),
    .phase_step_i   (phase_step_i),
    .amplitude_i    (amplitude_i),
    .duration_i     (duration_i),
    .done_o         (done_o),
    .sample_out_o   (sample_out_o),
    .sample_valid_o (sample_valid_o),
    .rejected_o     (rejected_o)
  );

endmodule

### tb/sv/scheduled_sine_voice_mixer_test.sv
// self-checking testbench for the scheduled sine voice mixer
module scheduled_sine_voice_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssvm_pkg::*;

  localparam int NumVoices = 16;
  localparam int TabSize   = 1024;
  localparam int IdleLimit = 4000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               valid;
    logic               rejected;
  } mix_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               func_i;
  logic [31:0]        start_delay_i;
  logic [23:0]        phase_step_i;
  logic [14:0]        amplitude_i;
  logic [31:0]        duration_i;
  logic               done_o;
  logic signed [15:0] sample_out_o;
  logic               sample_valid_o;
  logic               rejected_o;

  scheduled_sine_voice_mixer u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .start_delay_i, .phase_step_i,
    .amplitude_i, .duration_i, .done_o, .sample_out_o, .sample_valid_o, .rejected_o
  );

  // predictor state
  logic signed [15:0] sine_rom [TabSize];
  logic               slot_on   [NumVoices];
  logic [31:0]        slot_wait [NumVoices];
  logic [31:0]        slot_left [NumVoices];
  logic [23:0]        slot_phase[NumVoices];
  logic [23:0]        slot_step [NumVoices];
  logic [14:0]        slot_gain [NumVoices];

  mix_result_t pending_results[$];
  int          mismatches;
  int          idle_cycles;

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // q30 taylor sine of a quarter wave, 256 steps per quadrant
  function automatic int quarter_wave(longint unsigned j);
    longint unsigned theta, t, r, s, v;
    longint unsigned divs[5];
    divs = '{110, 72, 42, 20, 6};
    theta = (j * 64'd1686629713) / 256;
    t = (theta * theta) >> 30;
    r = 64'd1 << 30;
    for (int k = 0; k < 5; k++) r = (64'd1 << 30) - ((t * r) >> 30) / divs[k];
    s = (theta * r) >> 30;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  // full-wave table from quadrant symmetry
  task automatic build_sine_rom();
    int quad, j, v;
    for (int i = 0; i < TabSize; i++) begin
      quad = i / 256;
      j = i % 256;
      v = (quad & 1) ? quarter_wave(256 - j) : quarter_wave(j);
      sine_rom[i] = (quad >= 2) ? -v : v;
    end
  endtask

  // advance the voice model by one accepted transaction
  function automatic mix_result_t predict_mix(logic fn, logic [31:0] dly, logic [23:0] stp,
                                              logic [14:0] amp, logic [31:0] dur);
    mix_result_t res;
    longint acc, q;
    res = '0;
    if (fn == FUNC_SCHED) begin
      if (dur != 0) begin
        res.rejected = 1'b1;
        for (int v = 0; v < NumVoices; v++) begin
          if (!slot_on[v]) begin
            slot_on[v] = 1'b1;
            slot_wait[v] = dly;
            slot_left[v] = dur;
            slot_phase[v] = '0;
            slot_step[v] = stp;
            slot_gain[v] = amp;
            res.rejected = 1'b0;
            break;
          end
        end
      end
    end else begin
      acc = 0;
      for (int v = 0; v < NumVoices; v++) begin
        if (!slot_on[v]) continue;
        if (slot_wait[v] != 0) begin
          slot_wait[v]--;
          continue;
        end
        acc += longint'(slot_gain[v]) * longint'(sine_rom[slot_phase[v][23:14]]);
        slot_phase[v] = slot_phase[v] + slot_step[v];
        slot_left[v]--;
        if (slot_left[v] == 0) slot_on[v] = 1'b0;
      end
      q = (acc + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.sample = q[15:0];
      res.valid = 1'b1;
    end
    return res;
  endfunction

  // drive one transaction and wait until it is taken; start stays high
  task automatic send_item(logic fn, logic [31:0] dly, logic [23:0] stp,
                           logic [14:0] amp, logic [31:0] dur);
    start <= 1'b1;
    func_i <= fn;
    start_delay_i <= dly;
    phase_step_i <= stp;
    amplitude_i <= amp;
    duration_i <= dur;
    do @(posedge clk_i); while (busy);
    pending_results = {pending_results, predict_mix(fn, dly, stp, amp, dur)};
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  // result checker
  always @(posedge clk_i) begin
    mix_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result sample=%0d", sample_out_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (sample_out_o !== exp_res.sample || sample_valid_o !== exp_res.valid ||
            rejected_o !== exp_res.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sample=%0d valid=%0b rej=%0b got sample=%0d valid=%0b rej=%0b",
                     exp_res.sample, exp_res.valid, exp_res.rejected,
                     sample_out_o, sample_valid_o, rejected_o);
        end
      end
    end
  end

  // watchdog on cycles with no transaction and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // extremes, zero duration, saturation both ways
  task automatic test_extremes();
    send_tick();
    send_item(FUNC_SCHED, '1, '1, '1, 32'd0);
    send_item(FUNC_SCHED, 32'd0, 24'h0, 15'h7fff, 32'd1);
    send_tick();
    send_tick();
    for (int v = 0; v < NumVoices; v++) send_item(FUNC_SCHED, 32'd0, 24'h40_0000, 15'h7fff, 32'd2);
    send_tick();
    send_tick();
    for (int v = 0; v < NumVoices; v++) send_item(FUNC_SCHED, 32'd0, 24'hc0_0000, 15'h7fff, 32'd2);
    send_tick();
    send_tick();
    send_item(FUNC_SCHED, 32'd1, 24'hff_ffff, 15'h0, 32'd3);
    repeat (5) send_tick();
    pause_sender(3);
  endtask

  // fill every slot, see a rejection, then drain
  task automatic test_fill_and_reject();
    for (int v = 0; v < NumVoices; v++)
      send_item(FUNC_SCHED, $urandom_range(0, 3), $urandom, $urandom, $urandom_range(5, 30));
    send_item(FUNC_SCHED, $urandom, $urandom, $urandom, 32'd7);
    send_item(FUNC_SCHED, $urandom, $urandom, $urandom, 32'd0);
    repeat (36) send_tick();
    pause_sender(2);
  endtask

  // random bursts of mostly well-formed note traffic
  task automatic test_random(int count);
    int sent;
    int burst;
    logic [31:0] dly, dur;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 99) < 55) begin
          send_tick();
        end else begin
          dly = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 4);
          dur = $urandom_range(1, 40);
          case ($urandom_range(0, 19))
            0: dur = 32'd0;
            1: begin dly = $urandom; dur = 32'd0; end
            2: dur = $urandom_range(100, 300);
            default: ;
          endcase
          send_item(FUNC_SCHED, dly, $urandom, $urandom, dur);
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
    end
    pause_sender(1);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = FUNC_TICK;
    start_delay_i = '0;
    phase_step_i = '0;
    amplitude_i = '0;
    duration_i = '0;
    mismatches = 0;
    idle_cycles = 0;
    for (int v = 0; v < NumVoices; v++) slot_on[v] = 1'b0;
    build_sine_rom();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_fill_and_reject();
    test_random(750);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
